// ===== rtl/core/indirection_table_prng_core_macros.svh =====
// Assertion macros for the indirection table generator core.
// Used by the controller; needs clk_i and rst_ni in the enclosing scope.
`ifndef INDIRECTION_TABLE_PRNG_CORE_MACROS_SVH
`define INDIRECTION_TABLE_PRNG_CORE_MACROS_SVH

// Same-cycle implication under reset.
`define ITP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under reset.
`define ITP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/itp_pkg.sv =====
// Shared types and constants of the indirection table generator core.
// No dependencies.
`default_nettype none

package itp_pkg;

  localparam int unsigned TABLE_WORDS_DEF = 1024;
  localparam int unsigned ROT_LEFT        = 27;
  localparam int unsigned SEED_REFRESHES  = 100;
  localparam int unsigned RCNT_W          = $clog2(SEED_REFRESHES);

  localparam logic [31:0] LCG_MUL  = 32'd66049;
  localparam logic [31:0] LCG_ADD  = 32'd3907864577;
  localparam logic [31:0] STEP_MUL = 32'd69069;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [1:0] CMD_SEED = 2'd0;
  localparam logic [1:0] CMD_RAW  = 2'd1;
  localparam logic [1:0] CMD_MOD  = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_SEED_INIT,
    OP_SEED_STEP,
    OP_REF_START,
    OP_REF_RDX,
    OP_REF_RDY,
    OP_REF_WR,
    OP_BUF_RD,
    OP_BUF_TAKE,
    OP_NRD,
    OP_DIV,
    OP_DIV_TAKE,
    OP_RESP
  } itp_op_e;

  typedef enum logic [1:0] {
    DEST_TABLE,
    DEST_A,
    DEST_B
  } itp_dest_e;

  typedef enum logic [1:0] {
    DSEL_LIM,
    DSEL_VAL,
    DSEL_SIDX,
    DSEL_N
  } itp_dsel_e;

  typedef struct packed {
    itp_op_e   op;
    logic      half;
    itp_dest_e dest;
    itp_dsel_e dsel;
    logic      dec_n;
    logic      resp_zero;
    logic      resp_done;
  } itp_cmd_t;

  typedef struct packed {
    logic k_last;
    logic k_end;
    logic bit_last;
    logic wl_zero;
    logic n_zero;
    logic bound_small;
    logic v_ge_lim;
    logic div_busy;
  } itp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/itp_if.sv =====
// Request and response channel interfaces of the generator core.
// Depends on nothing; widths follow the request and response fields.
`default_nettype none

interface itp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] seed_first;
  logic [31:0] seed_second;
  logic [31:0] seed_third;
  logic [31:0] seed_fourth;
  logic [31:0] bound;

  modport source (output valid, command, seed_first, seed_second, seed_third,
                  seed_fourth, bound, input ready);
  modport sink (input valid, command, seed_first, seed_second, seed_third,
                seed_fourth, bound, output ready);
endinterface

interface itp_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        seed_done;

  modport source (output valid, value, seed_done, input ready);
  modport sink (input valid, value, seed_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/itp_div.sv =====
// Restoring divider, one quotient bit per cycle; gives the remainder.
// Depends on nothing.
`default_nettype none

module itp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic [31:0] rem_o
);

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [31:0] rem_q, dq_q, dvs_q;
  logic [32:0] trial, diff;
  logic        ge;

  assign trial = {rem_q, dq_q[31]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'd32;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dq_q  <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      dq_q  <= {dq_q[30:0], 1'b0};
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/core/itp_dp.sv =====
// Datapath: secret table, output buffer, accumulators, seeding streams.
// Depends on itp_pkg and itp_div.
`default_nettype none

module itp_dp #(
  parameter int unsigned TABLE_WORDS = itp_pkg::TABLE_WORDS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  itp_pkg::itp_cmd_t  cmd_i,
  input  logic [31:0]      seed_first_i,
  input  logic [31:0]      seed_second_i,
  input  logic [31:0]      seed_third_i,
  input  logic [31:0]      seed_fourth_i,
  input  logic [31:0]      bound_i,
  output itp_pkg::itp_stat_t st_o,
  output logic [31:0]      value_o,
  output logic             seed_done_o
);
  import itp_pkg::*;

  localparam int unsigned KW = $clog2(TABLE_WORDS);
  localparam int unsigned NW = KW + 1;
  localparam logic [KW-1:0] K_LAST = KW'(TABLE_WORDS - 1);
  localparam logic [NW-1:0] TWK    = NW'(TABLE_WORDS);
  localparam logic [31:0]   TW32   = 32'(TABLE_WORDS);
  // reciprocal of TABLE_WORDS, rounded up, scaled by 2^(32+KW)
  localparam int unsigned   RSH    = 32 + KW;
  localparam logic [32:0]   RCP    =
    33'(((64'd1 << RSH) + 64'(TABLE_WORDS) - 64'd1) / 64'(TABLE_WORDS));

  logic [31:0] tab_mem [TABLE_WORDS];
  logic [31:0] buf_mem [TABLE_WORDS];

  logic [KW-1:0] k_q, ri_q, wl_q, sidx_q;
  logic [NW-1:0] n_q;
  logic [4:0]    bit_q;
  logic [31:0]   a_q, b_q;
  logic [31:0]   s1_q, s2_q, s3_q, s4_q, bound_q;
  logic [31:0]   sx_q, sy_q, acc_q, xr_q, v_q, lim_q;
  logic [31:0]   tab_rd_q, buf_rd_q;
  logic [31:0]   out_value_q;
  logic          out_done_q;

  // seeding step
  logic [31:0] lcg_in, lcg_out, y0, y1, y2, xn, ssum, acc_n;
  logic        bit_last;

  assign lcg_in  = (cmd_i.op == OP_SEED_INIT) ? (cmd_i.half ? s3_q : s1_q) : sx_q;
  assign lcg_out = lcg_in * LCG_MUL + LCG_ADD;
  assign y0      = (sy_q == '0) ? lcg_out : sy_q;
  assign y1      = y0 ^ (y0 >> 15);
  assign y2      = y1 ^ (y1 << 17);
  assign xn      = sx_q * STEP_MUL;
  assign ssum    = xn + y2;
  assign acc_n   = cmd_i.half ? {acc_q[30:0], ssum[31]} : {ssum[31], acc_q[31:1]};
  assign bit_last = (bit_q == 5'd31);

  // refresh
  logic [32+KW:0] idx_prod;
  logic [KW-1:0]  idx;
  logic [31:0]    a_rot, a_n;

  assign idx_prod = {{NW{1'b0}}, tab_rd_q} * {32'd0, TWK};
  assign idx      = idx_prod[32 +: KW];
  assign a_rot    = (a_q << ROT_LEFT) | (a_q >> (32 - ROT_LEFT));
  assign a_n      = a_rot + tab_rd_q;

  // table port selection
  logic          tab_we, buf_we, seed_wr;
  logic [KW-1:0] tab_raddr;
  logic [31:0]   tab_wdata;

  assign seed_wr = (cmd_i.op == OP_SEED_STEP) && bit_last && (cmd_i.dest == DEST_TABLE);
  assign tab_we  = (cmd_i.op == OP_CLEAR) || (cmd_i.op == OP_REF_WR) || seed_wr;
  assign buf_we  = (cmd_i.op == OP_REF_WR);

  always_comb begin
    case (cmd_i.op)
      OP_REF_RDY: tab_raddr = idx;
      OP_NRD:     tab_raddr = sidx_q;
      default:    tab_raddr = k_q;
    endcase
    case (cmd_i.op)
      OP_CLEAR:  tab_wdata = '0;
      OP_REF_WR: tab_wdata = a_n + b_q;
      default:   tab_wdata = cmd_i.half ? (tab_rd_q ^ acc_n) : acc_n;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) tab_mem[k_q] <= tab_wdata;
    tab_rd_q <= tab_mem[tab_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) buf_mem[k_q] <= b_q + tab_rd_q;
    buf_rd_q <= buf_mem[ri_q];
  end

  // shared divider for the bound; remainders by TABLE_WORDS skip it
  logic        div_start, div_busy;
  logic [31:0] div_dvd, div_dvs, div_rem;

  assign div_start = (cmd_i.op == OP_DIV) &&
                     ((cmd_i.dsel == DSEL_LIM) || (cmd_i.dsel == DSEL_VAL));

  always_comb begin
    case (cmd_i.dsel)
      DSEL_LIM:  begin div_dvd = ALL_ONES;                   div_dvs = bound_q; end
      DSEL_VAL:  begin div_dvd = v_q;                        div_dvs = bound_q; end
      DSEL_SIDX: begin div_dvd = s1_q ^ s2_q ^ s3_q ^ s4_q;  div_dvs = TW32;    end
      default:   begin div_dvd = tab_rd_q;                   div_dvs = TW32;    end
    endcase
  end

  itp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .rem_o      (div_rem)
  );

  // remainder by TABLE_WORDS: register the reciprocal quotient, then subtract
  logic [64:0] rcp_prod;
  logic [31:0] rq_q, rx_q, rcp_rem;

  assign rcp_prod = {33'd0, div_dvd} * {32'd0, RCP};
  assign rcp_rem  = rx_q - rq_q * TW32;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= '0;
      ri_q  <= '0;
      wl_q  <= '0;
      n_q   <= '0;
      bit_q <= '0;
      a_q   <= '0;
      b_q   <= '0;
    end else begin
      if (cmd_i.dec_n) n_q <= n_q - NW'(1);
      case (cmd_i.op)
        OP_CLEAR: k_q <= (k_q == K_LAST) ? '0 : k_q + KW'(1);
        OP_SEED_INIT: begin
          bit_q <= '0;
          k_q   <= cmd_i.half ? '0 : K_LAST;
        end
        OP_SEED_STEP: begin
          bit_q <= bit_q + 5'd1;
          if (bit_last) begin
            case (cmd_i.dest)
              DEST_TABLE: k_q <= cmd_i.half ? ((k_q == K_LAST) ? '0 : k_q + KW'(1))
                                            : k_q - KW'(1);
              DEST_A:     a_q <= cmd_i.half ? (a_q ^ acc_n) : acc_n;
              default:    b_q <= cmd_i.half ? (b_q ^ acc_n) : acc_n;
            endcase
          end
        end
        OP_REF_START: k_q <= '0;
        OP_REF_WR: begin
          a_q <= a_n;
          b_q <= xr_q;
          if (k_q == K_LAST) begin
            k_q  <= '0;
            wl_q <= K_LAST;
            ri_q <= KW'(1);
          end else begin
            k_q <= k_q + KW'(1);
          end
        end
        OP_BUF_RD: begin
          wl_q <= wl_q - KW'(1);
          ri_q <= (ri_q == K_LAST) ? '0 : ri_q + KW'(1);
        end
        OP_DIV_TAKE: if (cmd_i.dsel == DSEL_N) n_q <= NW'(rcp_rem[KW-1:0]) + NW'(1);
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        s1_q    <= seed_first_i;
        s2_q    <= seed_second_i;
        s3_q    <= seed_third_i;
        s4_q    <= seed_fourth_i;
        bound_q <= bound_i;
      end
      OP_SEED_INIT: begin
        sx_q <= lcg_in[0] ? lcg_in : lcg_out;
        sy_q <= cmd_i.half ? s4_q : s2_q;
        if (!cmd_i.half) acc_q <= '0;
      end
      OP_SEED_STEP: begin
        sx_q  <= xn;
        sy_q  <= y2;
        acc_q <= acc_n;
      end
      OP_REF_RDY: xr_q <= tab_rd_q;
      OP_REF_WR:  if (k_q == '0) v_q <= b_q + tab_rd_q;
      OP_BUF_TAKE: v_q <= buf_rd_q;
      OP_DIV: begin
        rx_q <= div_dvd;
        rq_q <= 32'(rcp_prod >> RSH);
      end
      OP_DIV_TAKE: begin
        case (cmd_i.dsel)
          DSEL_LIM:  lim_q  <= ~div_rem;
          DSEL_VAL:  v_q    <= div_rem;
          DSEL_SIDX: sidx_q <= rcp_rem[KW-1:0];
          default: ;
        endcase
      end
      OP_RESP: begin
        out_value_q <= cmd_i.resp_zero ? '0 : v_q;
        out_done_q  <= cmd_i.resp_done;
      end
      default: ;
    endcase
  end

  assign st_o.k_last      = (k_q == K_LAST);
  assign st_o.k_end       = cmd_i.half ? (k_q == K_LAST) : (k_q == '0);
  assign st_o.bit_last    = bit_last;
  assign st_o.wl_zero     = (wl_q == '0);
  assign st_o.n_zero      = (n_q == '0);
  assign st_o.bound_small = (bound_q < 32'd2);
  assign st_o.v_ge_lim    = (v_q >= lim_q);
  assign st_o.div_busy    = div_busy;

  assign value_o     = out_value_q;
  assign seed_done_o = out_done_q;

endmodule

`default_nettype wire

// ===== rtl/core/itp_ctrl.sv =====
// Controller state machine: sequences clearing, seeding, refresh and draws.
// Depends on itp_pkg and the assertion macro header.
`default_nettype none
`include "indirection_table_prng_core_macros.svh"

module itp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         in_command_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output itp_pkg::itp_cmd_t  dp_cmd_o,
  input  itp_pkg::itp_stat_t st_i
);
  import itp_pkg::*;

  localparam logic [4:0] ST_CLEAR     = 5'd0;
  localparam logic [4:0] ST_IDLE      = 5'd1;
  localparam logic [4:0] ST_MSTART    = 5'd2;
  localparam logic [4:0] ST_DIV_GO    = 5'd3;
  localparam logic [4:0] ST_DIV_WAIT  = 5'd4;
  localparam logic [4:0] ST_DRAW      = 5'd5;
  localparam logic [4:0] ST_BUF_TAKE  = 5'd6;
  localparam logic [4:0] ST_MCHK      = 5'd7;
  localparam logic [4:0] ST_REF_START = 5'd8;
  localparam logic [4:0] ST_REF_RDX   = 5'd9;
  localparam logic [4:0] ST_REF_RDY   = 5'd10;
  localparam logic [4:0] ST_REF_WR    = 5'd11;
  localparam logic [4:0] ST_S_INIT1   = 5'd12;
  localparam logic [4:0] ST_S_W1      = 5'd13;
  localparam logic [4:0] ST_S_A1      = 5'd14;
  localparam logic [4:0] ST_S_B1      = 5'd15;
  localparam logic [4:0] ST_S_INIT2   = 5'd16;
  localparam logic [4:0] ST_S_W2      = 5'd17;
  localparam logic [4:0] ST_S_A2      = 5'd18;
  localparam logic [4:0] ST_S_B2      = 5'd19;
  localparam logic [4:0] ST_NRD       = 5'd20;
  localparam logic [4:0] ST_SKIP      = 5'd21;
  localparam logic [4:0] ST_RESP      = 5'd22;

  localparam logic [1:0] CTX_DRAW    = 2'd0;
  localparam logic [1:0] CTX_SEEDREF = 2'd1;
  localparam logic [1:0] CTX_SKIP    = 2'd2;

  localparam logic [RCNT_W-1:0] RCNT_LAST = RCNT_W'(SEED_REFRESHES - 1);

  logic [4:0]        state_q, state_d, post_draw;
  logic [1:0]        ctx_q, ctx_d, cmd_q, cmd_d;
  itp_dsel_e         dsel_q, dsel_d;
  logic [RCNT_W-1:0] rcnt_q, rcnt_d;
  logic              out_valid_q, out_valid_d;
  itp_cmd_t          dp_cmd;

  assign post_draw = (cmd_q == CMD_MOD) ? ST_MCHK : ST_RESP;

  always_comb begin
    state_d     = state_q;
    ctx_d       = ctx_q;
    cmd_d       = cmd_q;
    dsel_d      = dsel_q;
    rcnt_d      = rcnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    dp_cmd      = '0;
    dp_cmd.dsel = dsel_q;
    case (state_q)
      ST_CLEAR: begin
        dp_cmd.op = OP_CLEAR;
        if (st_i.k_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dp_cmd.op = OP_LOAD;
          cmd_d     = in_command_i;
          ctx_d     = CTX_DRAW;
          case (in_command_i)
            CMD_SEED: state_d = ST_S_INIT1;
            CMD_RAW:  state_d = ST_DRAW;
            CMD_MOD:  state_d = ST_MSTART;
            default:  state_d = ST_RESP;
          endcase
        end
      end
      ST_MSTART: begin
        if (st_i.bound_small) begin
          state_d = ST_RESP;
        end else begin
          dsel_d  = DSEL_LIM;
          state_d = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        dp_cmd.op = OP_DIV;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!st_i.div_busy) begin
          dp_cmd.op = OP_DIV_TAKE;
          case (dsel_q)
            DSEL_LIM:  state_d = ST_DRAW;
            DSEL_VAL:  state_d = ST_RESP;
            DSEL_SIDX: state_d = ST_NRD;
            default:   state_d = ST_SKIP;
          endcase
        end
      end
      ST_DRAW: begin
        if (st_i.wl_zero) begin
          state_d = ST_REF_START;
        end else begin
          dp_cmd.op = OP_BUF_RD;
          state_d   = ST_BUF_TAKE;
        end
      end
      ST_BUF_TAKE: begin
        dp_cmd.op = OP_BUF_TAKE;
        state_d   = post_draw;
      end
      ST_MCHK: begin
        // reject draws at or above the largest multiple of the bound
        if (st_i.v_ge_lim) begin
          state_d = ST_DRAW;
        end else begin
          dsel_d  = DSEL_VAL;
          state_d = ST_DIV_GO;
        end
      end
      ST_REF_START: begin
        dp_cmd.op = OP_REF_START;
        state_d   = ST_REF_RDX;
      end
      ST_REF_RDX: begin
        dp_cmd.op = OP_REF_RDX;
        state_d   = ST_REF_RDY;
      end
      ST_REF_RDY: begin
        dp_cmd.op = OP_REF_RDY;
        state_d   = ST_REF_WR;
      end
      ST_REF_WR: begin
        dp_cmd.op = OP_REF_WR;
        if (!st_i.k_last) begin
          state_d = ST_REF_RDX;
        end else begin
          case (ctx_q)
            CTX_SEEDREF: begin
              if (rcnt_q == RCNT_LAST) begin
                dsel_d  = DSEL_SIDX;
                state_d = ST_DIV_GO;
              end else begin
                rcnt_d  = rcnt_q + RCNT_W'(1);
                state_d = ST_REF_START;
              end
            end
            CTX_SKIP: state_d = ST_SKIP;
            default:  state_d = post_draw;
          endcase
        end
      end
      ST_S_INIT1: begin
        dp_cmd.op = OP_SEED_INIT;
        state_d   = ST_S_W1;
      end
      ST_S_W1: begin
        dp_cmd.op   = OP_SEED_STEP;
        dp_cmd.dest = DEST_TABLE;
        if (st_i.bit_last && st_i.k_end) state_d = ST_S_A1;
      end
      ST_S_A1: begin
        dp_cmd.op   = OP_SEED_STEP;
        dp_cmd.dest = DEST_A;
        if (st_i.bit_last) state_d = ST_S_B1;
      end
      ST_S_B1: begin
        dp_cmd.op   = OP_SEED_STEP;
        dp_cmd.dest = DEST_B;
        if (st_i.bit_last) state_d = ST_S_INIT2;
      end
      ST_S_INIT2: begin
        dp_cmd.op   = OP_SEED_INIT;
        dp_cmd.half = 1'b1;
        state_d     = ST_S_W2;
      end
      ST_S_W2: begin
        dp_cmd.op   = OP_SEED_STEP;
        dp_cmd.half = 1'b1;
        dp_cmd.dest = DEST_TABLE;
        if (st_i.bit_last && st_i.k_end) state_d = ST_S_A2;
      end
      ST_S_A2: begin
        dp_cmd.op   = OP_SEED_STEP;
        dp_cmd.half = 1'b1;
        dp_cmd.dest = DEST_A;
        if (st_i.bit_last) state_d = ST_S_B2;
      end
      ST_S_B2: begin
        dp_cmd.op   = OP_SEED_STEP;
        dp_cmd.half = 1'b1;
        dp_cmd.dest = DEST_B;
        if (st_i.bit_last) begin
          rcnt_d  = '0;
          ctx_d   = CTX_SEEDREF;
          state_d = ST_REF_START;
        end
      end
      ST_NRD: begin
        dp_cmd.op = OP_NRD;
        dsel_d    = DSEL_N;
        state_d   = ST_DIV_GO;
      end
      ST_SKIP: begin
        // discard the seed-dependent number of draws
        ctx_d = CTX_SKIP;
        if (st_i.n_zero) begin
          state_d = ST_RESP;
        end else if (st_i.wl_zero) begin
          dp_cmd.dec_n = 1'b1;
          state_d      = ST_REF_START;
        end else begin
          dp_cmd.op    = OP_BUF_RD;
          dp_cmd.dec_n = 1'b1;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          dp_cmd.op        = OP_RESP;
          dp_cmd.resp_zero = !((cmd_q == CMD_RAW) ||
                               ((cmd_q == CMD_MOD) && !st_i.bound_small));
          dp_cmd.resp_done = (cmd_q == CMD_SEED);
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ctx_q       <= CTX_DRAW;
      cmd_q       <= CMD_SEED;
      dsel_q      <= DSEL_LIM;
      rcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctx_q       <= ctx_d;
      cmd_q       <= cmd_d;
      dsel_q      <= dsel_d;
      rcnt_q      <= rcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign dp_cmd_o    = dp_cmd;
  assign out_valid_o = out_valid_q;

  `ITP_ASSERT_IMP(a_resp_slot_free, dp_cmd.op == OP_RESP, !out_valid_q || out_ready_i, "response overwrites a pending result")
  `ITP_ASSERT_IMP(a_div_take_done, dp_cmd.op == OP_DIV_TAKE, !st_i.div_busy, "divider result taken while busy")
  `ITP_ASSERT_NXT(a_accept_leaves_idle, in_valid_i && in_ready_o, state_q != ST_IDLE, "request accepted but controller stayed idle")
  `ITP_ASSERT_IMP(a_valid_from_resp, $rose(out_valid_q), $past(state_q == ST_RESP), "result raised outside the response state")

endmodule

`default_nettype wire

// ===== rtl/core/indirection_table_prng_core.sv =====
// Top level of the indirection table random word generator.
// Depends on itp_pkg, itp_if, itp_dp and itp_ctrl.
//
// The core takes one request at a time and returns exactly one response per
// request. After reset it sweeps the secret table to zero, one word a cycle,
// and holds req_i.ready low meanwhile. A raw draw (command 1) served from the
// output buffer passes the draw, buffer-take and response states, and the
// next request can be taken in the cycle in which rsp_o.valid rises; when the
// buffer is empty a refresh pass runs first over every table word (read word,
// indirect read, write back) through the single table port, once every
// TABLE_WORDS draws. A modulo draw (command 2) adds two passes of the
// bit-serial divider plus one draw per rejected word; a bound below 2 answers
// with zero at once. A seed request (command 0) steps the two seed streams one
// bit per cycle, then runs 100 refresh passes, two reductions modulo
// TABLE_WORDS by reciprocal multiplication and up to TABLE_WORDS skipped
// draws; it answers with value 0 and seed_done set. Command 3 changes nothing
// and answers with zero. A new request is taken while the previous response
// still waits in the output register.
`default_nettype none

module indirection_table_prng_core #(
  parameter int unsigned TABLE_WORDS = itp_pkg::TABLE_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  itp_req_if.sink     req_i,
  itp_rsp_if.source   rsp_o
);
  import itp_pkg::*;

  itp_cmd_t  dp_cmd;
  itp_stat_t dp_stat;

  // sequence the datapath; own the handshakes
  itp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_i.valid),
    .in_command_i (req_i.command),
    .in_ready_o   (req_i.ready),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .dp_cmd_o     (dp_cmd),
    .st_i         (dp_stat)
  );

  // hold tables, accumulators and the response register
  itp_dp #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .seed_first_i  (req_i.seed_first),
    .seed_second_i (req_i.seed_second),
    .seed_third_i  (req_i.seed_third),
    .seed_fourth_i (req_i.seed_fourth),
    .bound_i       (req_i.bound),
    .st_o          (dp_stat),
    .value_o       (rsp_o.value),
    .seed_done_o   (rsp_o.seed_done)
  );

endmodule

`default_nettype wire
